### hw/rtl/bsm_pkg.sv
// Shared types and constants for the radix-2 Booth signed multiplier.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package bsm_pkg;

   localparam int IN_BITS  = 16;
   localparam int OUT_BITS = 32;

   typedef logic signed [IN_BITS-1:0]  operand_type;
   typedef logic signed [OUT_BITS-1:0] product_type;

   // Booth recoding of {q0, q_1}
   localparam logic [1:0] BOOTH_ADD = 2'b01;
   localparam logic [1:0] BOOTH_SUB = 2'b10;

endpackage

### hw/rtl/bsm_req_if.sv
// Request channel: valid/ready handshake carrying the two operands.
// Depends on bsm_pkg.
`timescale 1ns / 1ps

interface bsm_req_if;
   import bsm_pkg::*;

   logic        valid;
   logic        ready;
   operand_type multiplicand;
   operand_type multiplier;

   modport source (output valid, output multiplicand, output multiplier, input ready);
   modport sink   (input valid, input multiplicand, input multiplier, output ready);

endinterface

### hw/rtl/bsm_rsp_if.sv
// Response channel: valid/ready handshake carrying the product.
// Depends on bsm_pkg.
`timescale 1ns / 1ps

interface bsm_rsp_if;
   import bsm_pkg::*;

   logic        valid;
   logic        ready;
   product_type product;

   modport source (output valid, output product, input ready);
   modport sink   (input valid, input product, output ready);

endinterface

### hw/rtl/booth_signed_multiplier_top.sv
// Pipelined radix-2 Booth signed multiplier, one Booth step per stage.
// Depends on bsm_pkg, bsm_req_if, bsm_rsp_if.
//
// Usage:
//   req_chan takes a request (multiplicand, multiplier) when valid and ready
//   are both high. rsp_chan returns the signed product, one response per
//   request, in request order.
//   Operands: low WIDTH+1 / WIDTH bits of the sign-extended 16-bit fields.
//   The product is 2*WIDTH bits, zero-extended or truncated to 32 bits.
//   Pipeline: WIDTH + 1 register stages; a request taken into stage 0
//   passes through the stages in order to the output stage on rsp_chan.
//   Throughput: one request per cycle while rsp_chan takes responses; each step
//   between stages is one add/subtract of WIDTH+1 bits and a one-bit shift.
//   Reset (synchronous, active high) clears all stage valid bits; the pipe
//   comes up empty with req_chan.ready high.
//   Stall: while the output stage holds a response that rsp_chan does not
//   take, the whole pipe freezes and req_chan.ready is low. Nothing is lost
//   or repeated.
`timescale 1ns / 1ps

module booth_signed_multiplier_top #(
   parameter int WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   bsm_req_if.sink   req_chan,
   bsm_rsp_if.source rsp_chan
);
   import bsm_pkg::*;

   localparam int PROD_BITS = 2 * WIDTH;

   logic             valid_ff [0:WIDTH];
   logic [WIDTH:0]   acc_ff   [0:WIDTH];
   logic [WIDTH:0]   acc_in   [0:WIDTH];
   logic [WIDTH-1:0] q_ff     [0:WIDTH];
   logic [WIDTH-1:0] q_in     [0:WIDTH];
   logic             q1_ff    [0:WIDTH];
   logic             q1_in    [0:WIDTH];
   logic [WIDTH:0]   m_ff     [0:WIDTH];
   logic [WIDTH:0]   m_in     [0:WIDTH];

   logic                 advance;
   logic [WIDTH:0]       mcand_ext;
   logic [WIDTH-1:0]     mplier_op;
   logic [PROD_BITS-1:0] prod_full;

   assign advance       = !valid_ff[WIDTH] || rsp_chan.ready;
   assign req_chan.ready = advance;

   // operand extraction
   if (WIDTH + 1 <= IN_BITS) begin : g_mcand_trunc
      assign mcand_ext = req_chan.multiplicand[WIDTH:0];
   end else begin : g_mcand_sext
      assign mcand_ext = {{(WIDTH + 1 - IN_BITS){req_chan.multiplicand[IN_BITS-1]}},
                          req_chan.multiplicand};
   end

   if (WIDTH <= IN_BITS) begin : g_mplier_trunc
      assign mplier_op = req_chan.multiplier[WIDTH-1:0];
   end else begin : g_mplier_sext
      assign mplier_op = {{(WIDTH - IN_BITS){req_chan.multiplier[IN_BITS-1]}},
                          req_chan.multiplier};
   end

   assign acc_in[0] = '0;
   assign q_in[0]   = mplier_op;
   assign q1_in[0]  = 1'b0;
   assign m_in[0]   = mcand_ext;

   // one Booth step between consecutive stages
   for (genvar s = 0; s < WIDTH; s++) begin : g_step
      logic [WIDTH:0] sum_w;

      always_comb begin
         case ({q_ff[s][0], q1_ff[s]})
            BOOTH_SUB: sum_w = acc_ff[s] - m_ff[s];
            BOOTH_ADD: sum_w = acc_ff[s] + m_ff[s];
            default:   sum_w = acc_ff[s];
         endcase
      end

      assign acc_in[s+1] = {sum_w[WIDTH], sum_w[WIDTH:1]};
      assign q_in[s+1]   = {sum_w[0], q_ff[s][WIDTH-1:1]};
      assign q1_in[s+1]  = q_ff[s][0];
      assign m_in[s+1]   = m_ff[s];
   end

   // stage registers
   for (genvar s = 0; s <= WIDTH; s++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= (s == 0) ? req_chan.valid : valid_ff[(s == 0) ? 0 : s - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            acc_ff[s] <= acc_in[s];
            q_ff[s]   <= q_in[s];
            q1_ff[s]  <= q1_in[s];
            m_ff[s]   <= m_in[s];
         end
      end
   end

   assign prod_full = {acc_ff[WIDTH][WIDTH-1:0], q_ff[WIDTH]};

   if (PROD_BITS >= OUT_BITS) begin : g_prod_trunc
      assign rsp_chan.product = prod_full[OUT_BITS-1:0];
   end else begin : g_prod_zext
      assign rsp_chan.product = {{(OUT_BITS - PROD_BITS){1'b0}}, prod_full};
   end

   assign rsp_chan.valid = valid_ff[WIDTH];

   // checks
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !valid_ff[0] && !valid_ff[WIDTH])
      else $error("pipeline not empty after reset");

   a_load_clean: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (acc_ff[0] == '0) && !q1_ff[0])
      else $error("first stage loaded with nonzero accumulator or extra bit");

   a_mcand_carried: assert property (@(posedge clock) disable iff (reset)
      advance && valid_ff[WIDTH-1] |=> m_ff[WIDTH] == $past(m_ff[WIDTH-1]))
      else $error("multiplicand changed between stages");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> valid_ff[WIDTH] && !rsp_chan.ready)
      else $error("request side stalled without a held response");

endmodule

### tb/bsm_checker.sv
// Response checker for the Booth signed multiplier: watches both channels, computes
// the expected product of every accepted request and compares it with each response.
// Depends on bsm_pkg, bsm_req_if, bsm_rsp_if.
`timescale 1ns / 1ps

module bsm_checker #(
   parameter int WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   bsm_req_if   req_chan,
   bsm_rsp_if   rsp_chan,
   output int   mismatches,
   output int   pending
);
   import bsm_pkg::*;

   product_type expected_products[$];

   // Radix-2 Booth recoding; accumulator one bit wider than the operand
   function automatic product_type booth_product(operand_type mcand, operand_type mplier);
      logic signed [63:0] wide_mcand;
      logic signed [63:0] wide_mplier;
      logic [WIDTH:0]     acc;
      logic [WIDTH:0]     addend;
      logic [WIDTH-1:0]   q;
      logic               q_prev;
      logic [2*WIDTH-1:0] full;
      product_type        result;
      wide_mcand  = 64'(mcand);
      wide_mplier = 64'(mplier);
      addend = wide_mcand[WIDTH:0];
      q      = wide_mplier[WIDTH-1:0];
      acc    = '0;
      q_prev = 1'b0;
      for (int step = 0; step < WIDTH; step++) begin
         case ({q[0], q_prev})
            BOOTH_SUB: acc = acc - addend;
            BOOTH_ADD: acc = acc + addend;
            default: ;
         endcase
         q_prev = q[0];
         q      = {acc[0], q[WIDTH-1:1]};
         acc    = {acc[WIDTH], acc[WIDTH:1]};
      end
      full   = {acc[WIDTH-1:0], q};
      result = OUT_BITS'(full);
      return result;
   endfunction

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      product_type want;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_products.size() == 0) begin
               $error("product: expected none, got %0d", rsp_chan.product);
               mismatches++;
            end else begin
               want = expected_products.pop_front();
               if (rsp_chan.product !== want) begin
                  $error("product: expected %0d, got %0d", want, rsp_chan.product);
                  mismatches++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_products.push_back(booth_product(req_chan.multiplicand,
                                                      req_chan.multiplier));
         pending = expected_products.size();
      end
   end

endmodule

### tb/tb.sv
// Testbench top for booth_signed_multiplier_top: clock, reset, request and response
// drivers with random idling, a long response hold-off, watchdog and final verdict.
// Depends on bsm_pkg, bsm_req_if, bsm_rsp_if, bsm_checker and the multiplier RTL.
`timescale 1ns / 1ps

module tb;
   import bsm_pkg::*;

   localparam int WIDTH       = 16;
   localparam int HOLD_CYCLES = 200;
   localparam int STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   send_idle;
   bit   recv_idle;
   bit   hold_request;
   int   mismatches;
   int   pending;
   int   quiet_cycles = 0;

   bsm_req_if req_chan ();
   bsm_rsp_if rsp_chan ();

   booth_signed_multiplier_top #(.WIDTH(WIDTH)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bsm_checker #(.WIDTH(WIDTH)) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   function automatic operand_type pick_operand();
      case ($urandom_range(0, 7))
         0: return operand_type'(-32768);
         1: return operand_type'(32767);
         2: return operand_type'(-1);
         3: return operand_type'($urandom_range(0, 1));
         default: return operand_type'($urandom);
      endcase
   endfunction

   // called and returns at a falling edge
   task automatic send_operands(operand_type mcand, operand_type mplier);
      int gap;
      gap = send_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.multiplicand <= mcand;
      req_chan.multiplier   <= mplier;
      forever begin
         @(posedge clock);
         if (req_chan.ready) break;
      end
      @(negedge clock);
   endtask

   task automatic drain_products();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // response side
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = recv_idle ? $urandom_range(0, 9) : 0;
         if (hold_request) begin
            hold_request = 1'b0;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         forever begin
            @(posedge clock);
            if (rsp_chan.valid) break;
         end
         @(negedge clock);
      end
   end

   // request side and verdict
   initial begin
      operand_type dir_mcand [18];
      operand_type dir_mplier[18];
      dir_mcand  = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'shFFFF,
                     16'sd0, 16'sd0, 16'sd1, 16'shFFFF, 16'h5555, 16'hAAAA, 16'h5555,
                     16'sh8000, 16'sd1, 16'sd12345, 16'sh8000, 16'sh7FFF};
      dir_mplier = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh8000,
                     16'sd0, 16'sh8000, 16'sd1, 16'shFFFF, 16'hAAAA, 16'h5555, 16'h5555,
                     16'sd1, 16'sh8000, 16'sd0, 16'sd0, 16'shFFFF};
      req_chan.valid        = 1'b0;
      req_chan.multiplicand = '0;
      req_chan.multiplier   = '0;
      send_idle    = 1'b1;
      recv_idle    = 1'b1;
      hold_request = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_mcand[i]) send_operands(dir_mcand[i], dir_mplier[i]);
      drain_products();

      send_idle = 1'b0;
      recv_idle = 1'b0;
      repeat (150) send_operands(pick_operand(), pick_operand());
      send_idle = 1'b1;
      recv_idle = 1'b1;
      repeat (150) send_operands(pick_operand(), pick_operand());
      drain_products();

      // response side stalls long while requests keep coming
      hold_request = 1'b1;
      send_idle    = 1'b0;
      repeat (60) send_operands(pick_operand(), pick_operand());
      send_idle = 1'b1;
      recv_idle = 1'b0;
      repeat (120) send_operands(pick_operand(), pick_operand());
      drain_products();

      send_idle = 1'b0;
      recv_idle = 1'b1;
      repeat (120) send_operands(pick_operand(), pick_operand());
      drain_products();

      repeat (WIDTH + 8) @(negedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
